### hdl/hrid_pkg.sv
// Shared types and constants for the Halton radical inverse text generator.
`timescale 1ns / 1ps

package hrid_pkg;

    // Field and datapath widths
    localparam int IDX_W   = 14;   // sequence index
    localparam int RADIX_W = 8;    // radix register
    localparam int CNT_W   = 6;    // digit count register
    localparam int CHAR_W  = 6;    // character code
    localparam int NUM_W   = 22;   // numerator and denominator, den < 2^22
    localparam int WORK_W  = 26;   // ten times the numerator
    localparam int DIG_W   = 4;    // one decimal digit
    localparam int STEP_W  = 2;    // restoring step counter within a decimal digit
    localparam int BIT_W   = 4;    // index bit counter within a base division

    // Configuration
    localparam int                 CFG_W          = RADIX_W;
    localparam logic               REG_RADIX      = 1'b0;
    localparam logic               REG_DIGITS     = 1'b1;
    localparam logic [RADIX_W-1:0] RADIX_RESET    = 8'd2;
    localparam logic [CNT_W-1:0]   DIGITS_RESET   = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MIN      = 8'd2;
    localparam int                 DEF_MAX_DIGITS = 62;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 6'd46;

    // Live configuration handed to the sequencer
    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [CNT_W-1:0]   digit_count;
    } t_cfg;

    // One output word
    typedef struct packed {
        logic              strobe;
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_res;

endpackage

### hdl/hrid_cmpsub.sv
// Shared compare-and-subtract unit used for every division step.
`timescale 1ns / 1ps

module hrid_cmpsub
    import hrid_pkg::*;
#(
    parameter int W = WORK_W
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_ge,
    output logic [W-1:0] o_diff
);

    // Subtract once, take the borrow as the compare result
    logic [W:0] w_sub;

    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[W];
    assign o_diff = w_sub[W-1:0];

endmodule

### hdl/hrid_ctrl.sv
// Sequencer and datapath registers: digit mirroring, then decimal expansion.
`timescale 1ns / 1ps

module hrid_ctrl
    import hrid_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [IDX_W-1:0] i_seq_index,
    input  t_cfg             i_cfg,
    output logic             o_busy,
    output t_res             o_res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_ZERO  = 3'd3;
    localparam logic [2:0] ST_POINT = 3'd4;
    localparam logic [2:0] ST_DIG   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    localparam logic [BIT_W-1:0]  LAST_BIT   = BIT_W'(IDX_W - 1);
    localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'(DIG_W - 1);
    localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_DIGITS);

    // Multiply by ten with two shifts and an add
    function automatic logic [WORK_W-1:0] times10(input logic [NUM_W-1:0] x);
        logic [WORK_W-1:0] xe;
        xe = {{(WORK_W-NUM_W){1'b0}}, x};
        return (xe << 3) + (xe << 1);
    endfunction

    logic [2:0]         r_state, n_state;
    logic [RADIX_W-1:0] r_base,  n_base;
    logic [CNT_W-1:0]   r_dig,   n_dig;
    logic [IDX_W-1:0]   r_quo,   n_quo;
    logic [RADIX_W:0]   r_rem,   n_rem;
    logic [BIT_W-1:0]   r_cnt,   n_cnt;
    logic [NUM_W-1:0]   r_num,   n_num;
    logic [NUM_W-1:0]   r_den,   n_den;
    logic [WORK_W-1:0]  r_work,  n_work;
    logic [STEP_W-1:0]  r_step,  n_step;
    logic [DIG_W-1:0]   r_digit, n_digit;

    logic [RADIX_W:0]         w_rem_sh;
    logic [WORK_W-1:0]        w_den_sh;
    logic [WORK_W-1:0]        w_cu_a;
    logic [WORK_W-1:0]        w_cu_b;
    logic                     w_cu_ge;
    logic [WORK_W-1:0]        w_cu_diff;
    logic [NUM_W+RADIX_W-1:0] w_num_prod;
    logic [NUM_W+RADIX_W-1:0] w_den_prod;
    logic [RADIX_W-1:0]       w_eff_radix;
    logic [CNT_W-1:0]         w_eff_cnt;

    // Clamp configuration into its working range
    always_comb begin
        w_eff_radix = (i_cfg.radix < RADIX_MIN) ? RADIX_MIN : i_cfg.radix;
        if (i_cfg.digit_count == '0) begin
            w_eff_cnt = CNT_W'(1);
        end else if (i_cfg.digit_count > MAX_CNT) begin
            w_eff_cnt = MAX_CNT;
        end else begin
            w_eff_cnt = i_cfg.digit_count;
        end
    end

    // Select operands of the shared unit
    always_comb begin
        w_rem_sh = {r_rem[RADIX_W-1:0], r_quo[IDX_W-1]};
        w_den_sh = {{(WORK_W-NUM_W){1'b0}}, r_den} << r_step;
        if (r_state == ST_DIV) begin
            w_cu_a = {{(WORK_W-RADIX_W-1){1'b0}}, w_rem_sh};
            w_cu_b = {{(WORK_W-RADIX_W){1'b0}}, r_base};
        end else begin
            w_cu_a = r_work;
            w_cu_b = w_den_sh;
        end
    end

    hrid_cmpsub #(
        .W (WORK_W)
    ) u_cmpsub (
        .i_a    (w_cu_a),
        .i_b    (w_cu_b),
        .o_ge   (w_cu_ge),
        .o_diff (w_cu_diff)
    );

    assign w_num_prod = r_num * r_base;
    assign w_den_prod = r_den * r_base;

    // Next state and datapath
    always_comb begin
        n_state = r_state;
        n_base  = r_base;
        n_dig   = r_dig;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_num   = r_num;
        n_den   = r_den;
        n_work  = r_work;
        n_step  = r_step;
        n_digit = r_digit;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_base  = w_eff_radix;
                    n_dig   = w_eff_cnt;
                    n_quo   = i_seq_index;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_num   = '0;
                    n_den   = NUM_W'(1);
                    n_state = (i_seq_index == '0) ? ST_ZERO : ST_DIV;
                end
            end
            ST_DIV: begin
                // one quotient bit per cycle; grow the denominator on the first
                if (r_cnt == '0) begin
                    n_den = w_den_prod[NUM_W-1:0];
                end
                n_rem = w_cu_ge ? w_cu_diff[RADIX_W:0] : w_rem_sh;
                n_quo = {r_quo[IDX_W-2:0], w_cu_ge};
                if (r_cnt == LAST_BIT) begin
                    n_cnt   = '0;
                    n_state = ST_ACC;
                end else begin
                    n_cnt = r_cnt + BIT_W'(1);
                end
            end
            ST_ACC: begin
                // append the base digit to the mirrored numerator
                n_num   = w_num_prod[NUM_W-1:0]
                        + {{(NUM_W-RADIX_W-1){1'b0}}, r_rem};
                n_rem   = '0;
                n_state = (r_quo == '0) ? ST_ZERO : ST_DIV;
            end
            ST_ZERO: begin
                n_state = ST_POINT;
            end
            ST_POINT: begin
                n_work  = times10(r_num);
                n_step  = FIRST_STEP;
                n_digit = '0;
                n_state = ST_DIG;
            end
            ST_DIG: begin
                // restoring division of ten times the remainder by den
                n_digit = {r_digit[DIG_W-2:0], w_cu_ge};
                if (w_cu_ge) begin
                    n_work = w_cu_diff;
                end
                if (r_step == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            ST_EMIT: begin
                if (r_dig == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_dig   = r_dig - CNT_W'(1);
                    n_work  = times10(r_work[NUM_W-1:0]);
                    n_step  = FIRST_STEP;
                    n_digit = '0;
                    n_state = ST_DIG;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance datapath registers
    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_dig   <= n_dig;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_num   <= n_num;
        r_den   <= n_den;
        r_work  <= n_work;
        r_step  <= n_step;
        r_digit <= n_digit;
    end

    // Drive the output word from the current state
    always_comb begin
        o_busy       = (r_state != ST_IDLE);
        o_res.strobe = (r_state == ST_ZERO) || (r_state == ST_POINT)
                    || (r_state == ST_EMIT);
        if (r_state == ST_POINT) begin
            o_res.code = CHAR_POINT;
        end else if (r_state == ST_EMIT) begin
            o_res.code = CHAR_ZERO + {{(CHAR_W-DIG_W){1'b0}}, r_digit};
        end else begin
            o_res.code = CHAR_ZERO;
        end
        o_res.last = (r_state == ST_EMIT) && (r_dig == CNT_W'(1));
    end

endmodule

### hdl/halton_radical_inverse_digits_top.sv
// Top level of the Halton radical inverse text generator.
`timescale 1ns / 1ps

// Usage:
//   Pulse start with seq_index while busy is low; the word is taken on that
//   edge and busy stays high until the final character has been sent.
//   Results appear one character per strobe on o_char_code: '0', '.', then
//   the configured number of decimal digits, clamped to 1..MAX_DIGITS; o_last
//   marks the final one. Each strobe lasts exactly one cycle and cannot be
//   held off by the receiver, so it must take every word as it comes.
//   Configuration: i_cfg_we with i_cfg_index (0 = radix, 1 = digit count)
//   and i_cfg_wdata; the user writes only while busy is low (not enforced).
// Sequence:
//   The index is loaded, then each base-radix digit takes 14 restoring
//   division steps on the shared compare-subtract unit plus one accumulate;
//   then "0." is sent, and each decimal digit takes four restoring steps plus
//   one output step. Index zero skips the base loop.
// Reset:
//   Synchronous, active low; the sequencer returns to idle, radix goes to 2
//   and digit count to 16.
module halton_radical_inverse_digits_top
    import hrid_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [IDX_W-1:0]  i_seq_index,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output logic              o_strobe,
    output logic [CHAR_W-1:0] o_char_code,
    output logic              o_last
);

    logic [RADIX_W-1:0] r_radix;
    logic [CNT_W-1:0]   r_digit_count;
    t_cfg               w_cfg;
    t_res               w_res;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix       <= RADIX_RESET;
            r_digit_count <= DIGITS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RADIX:  r_radix       <= i_cfg_wdata;
                REG_DIGITS: r_digit_count <= i_cfg_wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.radix       = r_radix;
    assign w_cfg.digit_count = r_digit_count;

    hrid_ctrl #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_seq_index (i_seq_index),
        .i_cfg       (w_cfg),
        .o_busy      (busy),
        .o_res       (w_res)
    );

    // Drive result ports
    assign o_strobe    = w_res.strobe;
    assign o_char_code = w_res.code;
    assign o_last      = w_res.last;

endmodule

### tb/halton_radical_inverse_digits_top_test.sv
// Self-checking testbench for the Halton radical inverse text generator.
`timescale 1ns / 1ps

module halton_radical_inverse_digits_top_test
    import hrid_pkg::*;
();

    // One expected output word: a character and its end-of-string flag
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [IDX_W-1:0]  i_seq_index;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_wdata;
    logic              o_strobe;
    logic [CHAR_W-1:0] o_char_code;
    logic              o_last;

    // Shadow copy of the configuration registers
    logic [RADIX_W-1:0] cfg_radix;
    logic [CNT_W-1:0]   cfg_digits;

    t_char_word expected_chars[$];
    int         error_count;
    int         indices_sent;
    int         chars_checked;
    int         settings_used;

    halton_radical_inverse_digits_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_seq_index (i_seq_index),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mirror the index digits and expand the fraction into decimal text
    function automatic void predict_string(input logic [IDX_W-1:0] seq_idx);
        longint unsigned base;
        longint unsigned count;
        longint unsigned rest;
        longint unsigned num;
        longint unsigned den;
        longint unsigned prod;
        longint unsigned d;
        t_char_word      w;
        base  = (cfg_radix < RADIX_MIN) ? longint'(RADIX_MIN) : longint'(cfg_radix);
        count = (cfg_digits == 0) ? 1 : cfg_digits;
        if (count > DEF_MAX_DIGITS)
            count = DEF_MAX_DIGITS;
        rest = seq_idx;
        num  = 0;
        den  = 1;
        while (rest != 0) begin
            den  = den * base;
            num  = num * base + rest % base;
            rest = rest / base;
        end
        w.code = CHAR_ZERO;
        w.last = 1'b0;
        expected_chars.push_back(w);
        w.code = CHAR_POINT;
        expected_chars.push_back(w);
        for (d = 0; d < count; d++) begin
            prod   = num * 10;
            w.code = CHAR_ZERO + CHAR_W'(prod / den);
            w.last = (d + 1 == count);
            expected_chars.push_back(w);
            num = prod % den;
        end
    endfunction

    // Check every strobed word against the oldest expectation
    always @(posedge i_clk) begin
        t_char_word want;
        if (i_rst_n && o_strobe) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected word code=%0d last=%0b",
                         $time, o_char_code, o_last);
                error_count++;
            end else begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (o_char_code !== want.code) begin
                    $display("%0t: char_code mismatch expected=%0d actual=%0d",
                             $time, want.code, o_char_code);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch expected=%0b actual=%0b",
                             $time, want.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // Wait for an edge at which the block reports idle
    task automatic wait_idle();
        do @(posedge i_clk); while (busy);
    endtask

    // Send one index after a random gap; return at the accepting edge
    task automatic send_index(input logic [IDX_W-1:0] seq_idx, input int max_gap);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            start <= 1'b0;
            // Let some gaps fall after the block has gone idle
            if ($urandom_range(0, 1))
                wait_idle();
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_seq_index <= seq_idx;
        do @(posedge i_clk); while (busy);
        predict_string(seq_idx);
        indices_sent++;
    endtask

    // Drop start and hold until every expected word is out and busy is low
    task automatic drain();
        start <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // Write both registers while idle
    task automatic set_config(input logic [RADIX_W-1:0] radix_val,
                              input logic [CNT_W-1:0] digits_val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_RADIX;
        i_cfg_wdata <= radix_val;
        @(posedge i_clk);
        cfg_radix   = radix_val;
        i_cfg_index <= REG_DIGITS;
        i_cfg_wdata <= CFG_W'(digits_val);
        @(posedge i_clk);
        cfg_digits  = digits_val;
        i_cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // Reset values of both registers
    task automatic test_reset_values();
        send_index(14'd0, 3);
        send_index(14'd1, 3);
        send_index(14'd5, 0);
        send_index(14'd16383, 2);
        drain();
    endtask

    // Radix below two, the largest radix, and the longest base loop
    task automatic test_radix_limits();
        set_config(8'd0, 6'd8);
        send_index(14'd6, 1);
        send_index(14'd13, 0);
        set_config(8'd1, 6'd8);
        send_index(14'd6, 2);
        set_config(8'd255, 6'd62);
        send_index(14'd16383, 0);
        send_index(14'd254, 3);
        send_index(14'd255, 0);
        set_config(8'd2, 6'd62);
        send_index(14'd16383, 1);
        drain();
    endtask

    // Digit count zero, above the cap, single digit; index past the nominal range
    task automatic test_digit_limits();
        set_config(8'd3, 6'd0);
        send_index(14'd7, 0);
        send_index(14'd0, 2);
        set_config(8'd7, 6'd63);
        send_index(14'd8192, 1);
        send_index(14'd100, 0);
        set_config(8'd10, 6'd1);
        send_index(14'd9999, 3);
        set_config(8'd13, 6'd62);
        send_index(14'd8193, 0);
        drain();
    endtask

    // Random settings, each followed by a batch of random indices
    task automatic test_random_batches();
        logic [RADIX_W-1:0] radix_val;
        logic [CNT_W-1:0]   digits_val;
        logic [IDX_W-1:0]   seq_idx;
        int                 max_gap;
        int                 pick;
        for (int phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 3))
                0: begin
                    pick = $urandom_range(0, 5);
                    radix_val = (pick == 0) ? 8'd2 : (pick == 1) ? 8'd3 :
                                (pick == 2) ? 8'd5 : (pick == 3) ? 8'd7 :
                                (pick == 4) ? 8'd11 : 8'd13;
                end
                1: radix_val = RADIX_W'($urandom_range(0, 255));
                2: radix_val = RADIX_W'($urandom_range(2, 16));
                default: radix_val = $urandom_range(0, 1) ? 8'd255 : 8'd128;
            endcase
            case ($urandom_range(0, 7))
                0: digits_val = 6'd62;
                1: digits_val = 6'd63;
                2: digits_val = 6'd0;
                default: digits_val = CNT_W'($urandom_range(1, 24));
            endcase
            set_config(radix_val, digits_val);
            // Run half the batches back to back
            max_gap = (phase % 2 == 0) ? 0 : 3;
            for (int k = 0; k < 12; k++) begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    seq_idx = '0;
                else if (pick < 3)
                    seq_idx = IDX_W'($urandom_range(8193, 16383));
                else
                    seq_idx = IDX_W'($urandom_range(0, 8192));
                send_index(seq_idx, max_gap);
            end
        end
        drain();
    endtask

    // Main sequence
    initial begin
        error_count   = 0;
        indices_sent  = 0;
        chars_checked = 0;
        settings_used = 0;
        cfg_radix     = RADIX_RESET;
        cfg_digits    = DIGITS_RESET;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_seq_index <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_RADIX;
        i_cfg_wdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_radix_limits();
        test_digit_limits();
        test_random_batches();

        // Let any trailing word appear before the final check
        repeat (16) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, expected_chars.size());
            error_count++;
        end
        $display("Sent %0d indices under %0d register settings plus reset values,",
                 indices_sent, settings_used);
        $display("checked %0d characters, %0d errors.", chars_checked, error_count);
        if (error_count == 0)
            $display("** halton_radical_inverse_digits_top: PASSED **");
        else
            $display("** halton_radical_inverse_digits_top: FAILED **");
        $finish;
    end

    // Stop a hung run
    initial begin
        #5000000;
        $display("Timeout at %0t", $time);
        $display("** halton_radical_inverse_digits_top: FAILED **");
        $finish;
    end

endmodule

### filelist.f
hdl/hrid_pkg.sv
hdl/hrid_cmpsub.sv
hdl/hrid_ctrl.sv
hdl/halton_radical_inverse_digits_top.sv
tb/halton_radical_inverse_digits_top_test.sv
